// File: rtl/bmxt_pkg.sv
// ----------------------------------------------------------------------------
// bmxt_pkg
// Shared constants, codes and types of the bounded maximum-xor trie.
// ----------------------------------------------------------------------------
package bmxt_pkg;

    localparam int VALUE_BITS = 32;
    localparam int NODE_COUNT = 32768;

    localparam int ADDR_W = $clog2(NODE_COUNT);
    localparam int CNT_W  = $clog2(NODE_COUNT + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int LVL_W  = $clog2(VALUE_BITS);
    localparam int LINK_W = 16;
    localparam int MIN_W  = 32;
    localparam int WORD_W = MIN_W + 2 * LINK_W;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FOUND    = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    typedef logic [2:0] t_mode;

    localparam t_mode MODE_IDLE  = 3'd0;
    localparam t_mode MODE_FIND  = 3'd1;
    localparam t_mode MODE_WRITE = 3'd2;
    localparam t_mode MODE_LEAF  = 3'd3;
    localparam t_mode MODE_QWALK = 3'd4;
    localparam t_mode MODE_HOLD  = 3'd5;

    typedef struct packed {
        logic  accept;
        t_mode mode;
        logic  out_load;
    } t_ctrl;

    typedef struct packed {
        logic find_end;
        logic full;
        logic lvl_zero;
        logic q_end;
    } t_stat;

    function automatic logic link_ok(input logic [LINK_W-1:0] link);
        return (link != '0) && ({1'b0, link} < (LINK_W + 1)'(NODE_COUNT));
    endfunction

endpackage

// File: rtl/bmxt_ctrl.sv
// ----------------------------------------------------------------------------
// bmxt_ctrl
// Sequencer of the trie: find and write passes of an insert, walk of a query,
// and the output valid flag.
// ----------------------------------------------------------------------------
module bmxt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  bmxt_pkg::t_stat  i_stat,
    output bmxt_pkg::t_ctrl  o_ctrl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_LEAF  = 3'd3;
    localparam logic [2:0] S_QWALK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_valid, n_valid;
    logic       accept;
    logic       out_load;

    assign s_tready = (r_state == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (r_state == S_DONE) && (!r_valid || m_tready);
    assign m_tvalid = r_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (s_tuser == bmxt_pkg::OP_QUERY) ? S_QWALK : S_FIND;
                end
            end
            S_FIND: begin
                if (i_stat.find_end) begin
                    n_state = i_stat.full ? S_DONE : S_WRITE;
                end
            end
            S_WRITE: begin
                if (i_stat.lvl_zero) begin
                    n_state = S_LEAF;
                end
            end
            S_LEAF: begin
                n_state = S_DONE;
            end
            S_QWALK: begin
                if (i_stat.q_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_valid = 1'b1;
        end else if (m_tready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_comb begin
        o_ctrl.accept   = accept;
        o_ctrl.out_load = out_load;
        unique case (r_state)
            S_FIND:  o_ctrl.mode = bmxt_pkg::MODE_FIND;
            S_WRITE: o_ctrl.mode = bmxt_pkg::MODE_WRITE;
            S_LEAF:  o_ctrl.mode = bmxt_pkg::MODE_LEAF;
            S_QWALK: o_ctrl.mode = bmxt_pkg::MODE_QWALK;
            S_DONE:  o_ctrl.mode = bmxt_pkg::MODE_HOLD;
            default: o_ctrl.mode = bmxt_pkg::MODE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

// File: rtl/bmxt_dpath.sv
// ----------------------------------------------------------------------------
// bmxt_dpath
// Node store with two read ports and one write port, path registers, level
// counter, node count and result registers.
// ----------------------------------------------------------------------------
module bmxt_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bmxt_pkg::t_ctrl                     i_ctrl,
    input  logic [bmxt_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic [bmxt_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [1:0]                          m_tuser,
    output bmxt_pkg::t_stat                     o_stat
);

    localparam int VB  = bmxt_pkg::VALUE_BITS;
    localparam int AW  = bmxt_pkg::ADDR_W;
    localparam int LW  = bmxt_pkg::LINK_W;
    localparam int MW  = bmxt_pkg::MIN_W;
    localparam int WW  = bmxt_pkg::WORD_W;
    localparam int CW  = bmxt_pkg::CNT_W;
    localparam int SW  = bmxt_pkg::SUM_W;
    localparam int LVW = bmxt_pkg::LVL_W;
    localparam int OUT_DATA_W_L = bmxt_pkg::OUT_DATA_W;

    logic [WW-1:0]  r_mem [bmxt_pkg::NODE_COUNT];
    logic [WW-1:0]  r_rd_a, r_rd_b;

    logic [VB-1:0]  r_val, r_key, r_v;
    logic [MW-1:0]  r_bound;
    logic [LVW-1:0] r_lvl;
    logic           r_at_root, r_fresh, r_first;
    logic [AW-1:0]  r_cur;
    logic           r_e0, r_e1;
    logic [CW-1:0]  r_nodes;
    logic [2*LW-1:0] r_root;
    logic [1:0]     r_res_status, r_o_status;
    logic [OUT_DATA_W_L-1:0] r_res_best, r_o_best;

    logic [2*LW-1:0] cur_links, new_links, wr_links;
    logic [MW-1:0]   cur_min, new_min, val_ext;
    logic            ins_bit, ins_ok;
    logic [LW-1:0]   ins_link, new_link, child_link;
    logic [SW-1:0]   need;
    logic            lvl_zero, find_end, full;

    logic            want, taken, ok0, ok1, want_ok, e_t, none, q_end;
    logic [WW-1:0]   t_word;
    logic [VB-1:0]   lvl_mask, v_next;

    logic [AW-1:0]   rd_addr_a, rd_addr_b;
    logic            we;

    assign val_ext  = MW'(r_val);
    assign lvl_zero = (r_lvl == '0);
    assign lvl_mask = VB'(1) << r_lvl;

    always_comb begin
        if (r_at_root) begin
            cur_links = r_root;
            cur_min   = val_ext;
        end else if (r_fresh) begin
            cur_links = '0;
            cur_min   = val_ext;
        end else begin
            cur_links = r_rd_a[2*LW-1:0];
            cur_min   = r_rd_a[WW-1:2*LW];
        end
    end

    assign ins_bit    = r_val[r_lvl];
    assign ins_link   = ins_bit ? cur_links[2*LW-1:LW] : cur_links[LW-1:0];
    assign ins_ok     = bmxt_pkg::link_ok(ins_link);
    assign need       = SW'(r_nodes) + (ins_ok ? SW'(0) : (SW'(r_lvl) + SW'(1)));
    assign find_end   = !ins_ok || lvl_zero;
    assign full       = find_end && (need > SW'(bmxt_pkg::NODE_COUNT));
    assign new_link   = LW'(r_nodes[AW-1:0]);
    assign child_link = ins_ok ? ins_link : new_link;
    assign new_links  = ins_bit ? {child_link, cur_links[LW-1:0]}
                                : {cur_links[2*LW-1:LW], child_link};
    assign new_min    = (cur_min > val_ext) ? val_ext : cur_min;
    assign wr_links   = (i_ctrl.mode == bmxt_pkg::MODE_LEAF) ? cur_links : new_links;

    assign want    = ~r_key[r_lvl];
    assign ok0     = r_e0 && (r_rd_a[WW-1:2*LW] <= r_bound);
    assign ok1     = r_e1 && (r_rd_b[WW-1:2*LW] <= r_bound);
    assign want_ok = want ? ok1 : ok0;
    assign taken   = want_ok ? want : ~want;
    assign e_t     = taken ? r_e1 : r_e0;
    assign t_word  = taken ? r_rd_b : r_rd_a;
    assign none    = r_first && !(ok0 || ok1);
    assign v_next  = (e_t && taken) ? (r_v | lvl_mask) : r_v;
    assign q_end   = none || !e_t || lvl_zero;

    always_comb begin
        rd_addr_a = r_root[AW-1:0];
        rd_addr_b = r_root[LW+AW-1:LW];
        unique case (i_ctrl.mode)
            bmxt_pkg::MODE_FIND,
            bmxt_pkg::MODE_WRITE: begin
                rd_addr_a = ins_link[AW-1:0];
            end
            bmxt_pkg::MODE_QWALK: begin
                rd_addr_a = t_word[AW-1:0];
                rd_addr_b = t_word[LW+AW-1:LW];
            end
            default: begin
                rd_addr_a = r_root[AW-1:0];
            end
        endcase
    end

    assign we = ((i_ctrl.mode == bmxt_pkg::MODE_WRITE) && !r_at_root)
             || (i_ctrl.mode == bmxt_pkg::MODE_LEAF);

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_cur] <= {new_min, wr_links};
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes <= CW'(1);
            r_root  <= '0;
        end else if (i_ctrl.mode == bmxt_pkg::MODE_WRITE) begin
            if (!ins_ok) begin
                r_nodes <= r_nodes + CW'(1);
            end
            if (r_at_root) begin
                r_root <= new_links;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.mode)
            bmxt_pkg::MODE_IDLE: begin
                r_e0 <= bmxt_pkg::link_ok(r_root[LW-1:0]);
                r_e1 <= bmxt_pkg::link_ok(r_root[2*LW-1:LW]);
                if (i_ctrl.accept) begin
                    r_val     <= s_tdata[VB-1:0];
                    r_key     <= s_tdata[32 +: VB];
                    r_bound   <= s_tdata[64 +: MW];
                    r_lvl     <= LVW'(VB - 1);
                    r_at_root <= 1'b1;
                    r_fresh   <= 1'b0;
                    r_first   <= 1'b1;
                    r_v       <= '0;
                end
            end
            bmxt_pkg::MODE_FIND: begin
                if (find_end) begin
                    r_lvl     <= LVW'(VB - 1);
                    r_at_root <= 1'b1;
                end else begin
                    r_lvl     <= r_lvl - LVW'(1);
                    r_at_root <= 1'b0;
                end
                if (full) begin
                    r_res_status <= bmxt_pkg::ST_FULL;
                    r_res_best   <= '0;
                end
            end
            bmxt_pkg::MODE_WRITE: begin
                r_cur     <= child_link[AW-1:0];
                r_at_root <= 1'b0;
                r_fresh   <= !ins_ok;
                if (!lvl_zero) begin
                    r_lvl <= r_lvl - LVW'(1);
                end
            end
            bmxt_pkg::MODE_LEAF: begin
                r_res_status <= bmxt_pkg::ST_INSERTED;
                r_res_best   <= '0;
            end
            bmxt_pkg::MODE_QWALK: begin
                r_e0    <= bmxt_pkg::link_ok(t_word[LW-1:0]);
                r_e1    <= bmxt_pkg::link_ok(t_word[2*LW-1:LW]);
                r_v     <= v_next;
                r_first <= 1'b0;
                if (!lvl_zero) begin
                    r_lvl <= r_lvl - LVW'(1);
                end
                if (q_end) begin
                    if (none) begin
                        r_res_status <= bmxt_pkg::ST_NONE;
                        r_res_best   <= '0;
                    end else begin
                        r_res_status <= bmxt_pkg::ST_FOUND;
                        r_res_best   <= OUT_DATA_W_L'(r_key ^ v_next);
                    end
                end
            end
            default: begin
                r_first <= r_first;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_o_status <= r_res_status;
            r_o_best   <= r_res_best;
        end
    end

    assign m_tdata = r_o_best;
    assign m_tuser = r_o_status;

    assign o_stat.find_end = find_end;
    assign o_stat.full     = full;
    assign o_stat.lvl_zero = lvl_zero;
    assign o_stat.q_end    = q_end;

endmodule

// File: rtl/bounded_max_xor_trie.sv
// ----------------------------------------------------------------------------
// bounded_max_xor_trie
// Binary trie of unsigned values with per-node minimum; inserts values and
// answers maximum key-xor queries over stored values not above a bound.
// ----------------------------------------------------------------------------
// channel   dir   tdata                                     tuser
// s_*       in    insert_value, query_key, bound (96 b)     opcode (1 b)
// m_*       out   best_xor (32 b)                           status (2 b)
//
// A query reads one node-store pair per trie level, since the two children of
// a node are read only after the node itself. An insert runs a find pass
// down the existing path, then, unless the store is full, a write pass that
// links new nodes and updates minimums. Reset sets the node count to one and
// clears root links, sequencer state and valid flag; the node store needs none.
// A new request is taken while the previous result still waits in the output
// register; a stalled output holds the finished item before the next result.
// ----------------------------------------------------------------------------
module bounded_max_xor_trie (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // insert_value [31:0], query_key [63:32], bound [95:64]
    input  logic [bmxt_pkg::IN_DATA_W-1:0]      s_tdata,
    // opcode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // best_xor [31:0]
    output logic [bmxt_pkg::OUT_DATA_W-1:0]     m_tdata,
    // status [1:0]
    output logic [1:0]                          m_tuser
);

    bmxt_pkg::t_ctrl ctrl;
    bmxt_pkg::t_stat stat;

    bmxt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .i_stat   (stat),
        .o_ctrl   (ctrl)
    );

    bmxt_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .o_stat  (stat)
    );

endmodule

// File: test/bmxt_trie_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmxt_trie_monitor
// Watches both stream channels of the max-xor trie. Keeps its own copy of the
// trie, works out the answer to every accepted request, and compares each
// returned answer with the oldest one still owed. Reports mismatches and the
// number of answers still owed.
// ----------------------------------------------------------------------------
module bmxt_trie_monitor
    import bmxt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    input  logic                    i_s_tready,
    // insert_value [31:0], query_key [63:32], bound [95:64]
    input  logic [IN_DATA_W-1:0]    i_s_tdata,
    // opcode
    input  logic                    i_s_tuser,
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    // best_xor [31:0]
    input  logic [OUT_DATA_W-1:0]   i_m_tdata,
    // status [1:0]
    input  logic [1:0]              i_m_tuser,
    output int                      o_errors,
    output int                      o_outstanding
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] best;
    } t_trie_answer;

    logic [WORD_W-1:0] node_mem [NODE_COUNT];
    int unsigned       nodes_used;
    logic [31:0]       root_links;
    t_trie_answer      owed_answers [$];
    int                error_count;

    function automatic int unsigned child_of(input int unsigned node, input logic b);
        logic [31:0] links;
        logic [15:0] c;
        if (node == 0)
            links = root_links;
        else if (node < NODE_COUNT)
            links = node_mem[node][31:0];
        else
            return 0;
        c = b ? links[31:16] : links[15:0];
        return (c < NODE_COUNT) ? c : 0;
    endfunction

    function automatic void link_child(input int unsigned node, input logic b,
                                       input int unsigned c);
        if (node == 0) begin
            if (b) root_links[31:16] = c[15:0];
            else   root_links[15:0]  = c[15:0];
        end else if (node < NODE_COUNT) begin
            if (b) node_mem[node][31:16] = c[15:0];
            else   node_mem[node][15:0]  = c[15:0];
        end
    endfunction

    function automatic logic [31:0] min_below(input int unsigned node);
        if (node == 0 || node >= NODE_COUNT)
            return 32'hFFFF_FFFF;
        return node_mem[node][63:32];
    endfunction

    function automatic logic [1:0] grow_trie(input logic [31:0] v);
        int unsigned node;
        int unsigned c;
        int unsigned missing;
        node    = 0;
        missing = 0;
        for (int lvl = VALUE_BITS - 1; lvl >= 0; lvl--) begin
            c = child_of(node, v[lvl]);
            if (c == 0) begin
                missing = lvl + 1;
                break;
            end
            node = c;
        end
        if (nodes_used + missing > NODE_COUNT)
            return ST_FULL;
        node = 0;
        for (int lvl = VALUE_BITS - 1; lvl >= 0; lvl--) begin
            c = child_of(node, v[lvl]);
            if (c == 0) begin
                c = nodes_used;
                nodes_used++;
                if (c == 0 || c >= NODE_COUNT)
                    return ST_FULL;
                node_mem[c] = {v, 32'h0};
                link_child(node, v[lvl], c);
            end else if (min_below(c) > v) begin
                node_mem[c][63:32] = v;
            end
            node = c;
        end
        return ST_INSERTED;
    endfunction

    function automatic t_trie_answer best_partner(input logic [31:0] k,
                                                  input logic [31:0] lim);
        t_trie_answer ans;
        int unsigned  node;
        int unsigned  c;
        int unsigned  c0;
        int unsigned  c1;
        logic         want;
        logic         taken;
        logic [31:0]  v;
        ans  = '{status: ST_NONE, best: 32'h0};
        node = 0;
        v    = '0;
        c0   = child_of(0, 1'b0);
        c1   = child_of(0, 1'b1);
        if (!((c0 != 0 && min_below(c0) <= lim) || (c1 != 0 && min_below(c1) <= lim)))
            return ans;
        for (int lvl = VALUE_BITS - 1; lvl >= 0; lvl--) begin
            want  = ~k[lvl];
            taken = want;
            c     = child_of(node, want);
            if (c == 0 || min_below(c) > lim) begin
                taken = ~want;
                c     = child_of(node, taken);
            end
            if (c == 0)
                break;
            v[lvl] = taken;
            node   = c;
        end
        ans.status = ST_FOUND;
        ans.best   = k ^ v;
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_trie_answer owed;
        t_trie_answer fresh;
        if (!i_rst_n) begin
            nodes_used  = 1;
            root_links  = '0;
            error_count = 0;
            owed_answers.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (owed_answers.size() == 0) begin
                    $display("%0t: unexpected result status %0d best_xor %h",
                             $time, i_m_tuser, i_m_tdata);
                    error_count++;
                end else begin
                    owed = owed_answers.pop_front();
                    if (i_m_tuser !== owed.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, owed.status, i_m_tuser);
                        error_count++;
                    end
                    if (i_m_tdata !== owed.best) begin
                        $display("%0t: best_xor expected %h actual %h",
                                 $time, owed.best, i_m_tdata);
                        error_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_INSERT) begin
                    fresh.status = grow_trie(i_s_tdata[31:0]);
                    fresh.best   = '0;
                end else begin
                    fresh = best_partner(i_s_tdata[63:32], i_s_tdata[95:64]);
                end
                owed_answers.push_back(fresh);
            end
        end
        o_errors      <= error_count;
        o_outstanding <= owed_answers.size();
    end

endmodule

// File: test/bounded_max_xor_trie_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_max_xor_trie_tb
// Regression for the bounded max-xor trie. Drives directed inserts and
// queries, then random ones under changing back-pressure and a long output
// stall, and finally near and repeated inserts of stored values before more random ones.
// ----------------------------------------------------------------------------
module bounded_max_xor_trie_tb;
    import bmxt_pkg::*;

    localparam int HOLD_CYCLES = 400;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [1:0]             m_tuser;

    int unsigned tx_idle   = 30;
    int unsigned rx_idle   = 82;
    logic        hold_go   = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          mismatches;
    int          outstanding;
    logic [31:0] stored [$];

    always #2 i_clk = ~i_clk;

    bounded_max_xor_trie uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    bmxt_trie_monitor monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_errors      (mismatches),
        .o_outstanding (outstanding)
    );

    // hold off the receiver for a stretch each time hold_go toggles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= hold_go;
        end else if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    task automatic offer(input logic op, input logic [31:0] val, input logic [31:0] key,
                         input logic [31:0] lim);
        while ($urandom_range(0, 99) < tx_idle) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom};
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {lim, key, val};
        if (op == OP_INSERT)
            stored.push_back(val);
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic logic [31:0] pick_stored();
        if (stored.size() == 0)
            return $urandom;
        return stored[$urandom_range(0, stored.size() - 1)];
    endfunction

    task automatic offer_random();
        logic [31:0] p;
        logic [31:0] a;
        logic [31:0] k;
        logic [31:0] b;
        p = pick_stored();
        if ($urandom_range(0, 99) < 40) begin
            case ($urandom_range(0, 4))
                0: a = $urandom;
                1: a = p;
                2: a = p ^ (32'd1 << $urandom_range(0, 31));
                3: a = $urandom_range(0, 15);
                default: a = ~$urandom_range(0, 15);
            endcase
            offer(OP_INSERT, a, $urandom, $urandom);
        end else begin
            case ($urandom_range(0, 3))
                0: k = $urandom;
                1: k = p;
                2: k = ~p;
                default: k = p ^ (32'd1 << $urandom_range(0, 31));
            endcase
            case ($urandom_range(0, 6))
                0: b = $urandom;
                1: b = p;
                2: b = p - 1;
                3: b = p + 1;
                4: b = 32'h0;
                5: b = 32'hFFFF_FFFF;
                default: b = $urandom >> $urandom_range(0, 31);
            endcase
            offer(OP_QUERY, $urandom, k, b);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        offer(OP_QUERY,  $urandom, 32'h0000_0000, 32'hFFFF_FFFF);
        offer(OP_INSERT, 32'h0000_0010, $urandom, $urandom);
        offer(OP_QUERY,  $urandom, 32'h0000_0000, 32'h0000_0005);
        offer(OP_QUERY,  $urandom, 32'h0000_0000, 32'h0000_0010);
        offer(OP_INSERT, 32'hFFFF_FFFF, $urandom, $urandom);
        offer(OP_INSERT, 32'h0000_0010, $urandom, $urandom);
        offer(OP_QUERY,  $urandom, 32'h0000_0000, 32'hFFFF_FFFF);
        offer(OP_QUERY,  $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        offer(OP_INSERT, 32'h0000_0000, $urandom, $urandom);
        offer(OP_QUERY,  $urandom, 32'h0000_0000, 32'h0000_0000);
        offer(OP_QUERY,  $urandom, 32'hFFFF_FFFF, 32'h0000_0000);
        offer(OP_INSERT, 32'h8000_0000, $urandom, $urandom);
        offer(OP_INSERT, 32'h7FFF_FFFF, $urandom, $urandom);
        offer(OP_QUERY,  $urandom, 32'h8000_0000, 32'h7FFF_FFFF);
        offer(OP_QUERY,  $urandom, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        offer(OP_QUERY,  $urandom, 32'hAAAA_AAAA, 32'h8000_0000);
        offer(OP_INSERT, 32'h5555_5555, $urandom, $urandom);
        offer(OP_QUERY,  $urandom, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
        offer(OP_QUERY,  $urandom, 32'h5555_5555, 32'h5555_5554);
        offer(OP_INSERT, 32'hFFFF_FFFF, $urandom, $urandom);

        repeat (110) offer_random();
        tx_idle = 82;
        rx_idle <= 30;
        repeat (110) offer_random();
        tx_idle = 0;
        rx_idle <= 0;
        repeat (50) offer_random();

        // stall the output while requests keep coming
        hold_go <= ~hold_go;
        repeat (12) offer_random();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (40) offer_random();

        // probe neighbors and repeats of stored values
        repeat (20) offer(OP_INSERT, pick_stored() ^ 32'd1, $urandom, $urandom);
        repeat (20) offer(OP_INSERT, pick_stored(), $urandom, $urandom);
        repeat (20) offer_random();

        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (80) @(posedge i_clk);
        if (mismatches == 0)
            $display("bounded_max_xor_trie regression: pass");
        else
            $display("bounded_max_xor_trie regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("bounded_max_xor_trie regression: fail");
        $finish;
    end

endmodule
